// File: rtl/icvf_pkg.sv
// shared constants, register codes and helpers of the isosurface crossing voxel finder
`default_nettype none

package icvf_pkg;

    localparam int VALUE_W     = 32;
    localparam int INDEX_W     = 18;
    localparam int SIZE_W      = 7;
    localparam int SIZE_MAX    = (1 << SIZE_W) - 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam int DEF_MAX_SIZE_X = 64;
    localparam int DEF_MAX_SIZE_Y = 64;
    localparam int DEF_MAX_SIZE_Z = 64;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_SIZE_X    = 2'd1,
        REG_SIZE_Y    = 2'd2,
        REG_SIZE_Z    = 2'd3
    } cfg_reg_t;

    // size registers hold values in [2, maxv]
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v < SIZE_W'(2)) begin
            r = SIZE_W'(2);
        end else if (v > maxv) begin
            r = maxv;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/isosurface_crossing_voxel_finder.sv
// top level: streaming isosurface crossing voxel finder over a one-plane buffer
`default_nettype none

// Takes one transaction per cycle while s_ready is high: a sample (s_mode 0) of a
// size_x*size_y*size_z volume in raster order, or a drain tick (s_mode 1). Once the first
// plane is in, every sample emits the voxel one plane behind it, with its linear index, value
// and crossing mark; after the whole volume has arrived, each drain tick emits one voxel of
// the final plane, the last one with m_last set, after which the next sample starts a new
// volume. Samples after a full volume and drains before it are taken and dropped. Results pass
// through stage 1 and the output queue; the plane memory (value, side and partial mark
// per slot, two registered read ports and one write port) and a one-bit row mark memory each
// see one access per port per cycle, so the sustained rate is one transaction per clock
// whenever m_ready keeps up. The buffers need no clearing after reset. Writing a size register
// restarts the volume and drops buffered voxels; a threshold write applies to later samples.
module isosurface_crossing_voxel_finder
    import icvf_pkg::*;
#(
    parameter int MAX_SIZE_X = DEF_MAX_SIZE_X,
    parameter int MAX_SIZE_Y = DEF_MAX_SIZE_Y,
    parameter int MAX_SIZE_Z = DEF_MAX_SIZE_Z
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_mode,
    input  wire logic [VALUE_W-1:0]    s_sample,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [INDEX_W-1:0]         m_voxel_index,
    output logic [VALUE_W-1:0]         m_voxel_value,
    output logic                       m_crossing,
    output logic                       m_last
);

    localparam int PLANE_DEPTH = MAX_SIZE_X * MAX_SIZE_Y;
    localparam int AW          = $clog2(PLANE_DEPTH);

    localparam logic [SIZE_W-1:0] CLAMP_X =
        (MAX_SIZE_X > SIZE_MAX) ? SIZE_W'(SIZE_MAX) : SIZE_W'(MAX_SIZE_X);
    localparam logic [SIZE_W-1:0] CLAMP_Y =
        (MAX_SIZE_Y > SIZE_MAX) ? SIZE_W'(SIZE_MAX) : SIZE_W'(MAX_SIZE_Y);
    localparam logic [SIZE_W-1:0] CLAMP_Z =
        (MAX_SIZE_Z > SIZE_MAX) ? SIZE_W'(SIZE_MAX) : SIZE_W'(MAX_SIZE_Z);

    typedef struct packed {
        logic               pmark;
        logic               side;
        logic [VALUE_W-1:0] value;
    } mem_word_t;

    typedef struct packed {
        logic [AW-1:0]      slot;
        logic               eor;
        logic               pmark;
        logic               side;
        logic [VALUE_W-1:0] value;
    } pend_t;

    typedef struct packed {
        logic               is_drain;
        logic               emit;
        logic               last;
        logic               side;
        logic               cx_nz;
        logic               cy_nz;
        logic               cz_nz;
        logic               lastrow;
        logic               eor;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] idx;
        logic [AW-1:0]      a_addr;
        logic [AW-1:0]      b_addr;
    } s1_t;

    typedef struct packed {
        logic [INDEX_W-1:0] idx;
        logic [VALUE_W-1:0] value;
        logic               crossing;
        logic               last;
    } out_t;

    // configuration
    logic [VALUE_W-1:0] thr_reg, thr_next;
    logic [SIZE_W-1:0]  sx_reg, sx_next, sy_reg, sy_next, sz_reg, sz_next;

    // stream position
    logic [SIZE_W-1:0]  cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic [AW-1:0]      slot_reg, slot_next;
    logic               full_reg, full_next;
    logic [INDEX_W-1:0] emit_pos_reg, emit_pos_next;
    logic               restart;

    // stage 1
    logic               s1_valid_reg, s1_valid_next;
    s1_t                s1_reg, s1_next;

    // entry waiting for its +x neighbor before the write
    logic               pend_valid_reg, pend_valid_next;
    pend_t              pend_reg, pend_next;

    // memories and same-edge bypass
    mem_word_t          plane_mem [PLANE_DEPTH];
    logic               ymark_mem [PLANE_DEPTH];
    mem_word_t          rd_a_reg, rd_b_reg;
    logic               ym_rd_reg;
    logic               bp_valid_reg;
    logic [AW-1:0]      bp_addr_reg;
    mem_word_t          bp_data_reg;
    logic               ym_bp_valid_reg;
    logic [AW-1:0]      ym_bp_addr_reg;
    logic               ym_bp_data_reg;

    logic               main_we;
    mem_word_t          main_wdata;
    logic               ym_we;
    logic               ym_wdata;
    logic [AW-1:0]      rd_b_addr;
    logic [AW+SIZE_W-1:0] b_wide;

    // output queue
    logic [1:0]         occ_reg, occ_next;
    out_t               out0_reg, out0_next, out1_reg, out1_next;

    logic               acc;
    logic               pop;
    logic               push;
    logic               s1_emit;
    logic               s1_sample;
    logic               wrap_x, wrap_y, wrap_z;
    mem_word_t          ent_a, ent_b;
    logic               ym_val;
    logic               xdiff, ydiff, zdiff;
    logic               pmark_new;
    out_t               res;

    assign s1_emit   = s1_valid_reg && s1_reg.emit;
    assign s1_sample = s1_valid_reg && !s1_reg.is_drain;
    assign pop       = m_valid && m_ready;
    assign push      = s1_emit;
    assign s_ready   = ({1'b0, occ_reg} + 3'(s1_emit)) <= (3'd1 + 3'(pop));
    assign acc       = s_valid && s_ready;

    assign wrap_x = (cx_reg == sx_reg - SIZE_W'(1));
    assign wrap_y = (cy_reg == sy_reg - SIZE_W'(1));
    assign wrap_z = (cz_reg == sz_reg - SIZE_W'(1));

    assign b_wide    = {{SIZE_W{1'b0}}, slot_reg} - {{AW{1'b0}}, sx_reg};
    assign rd_b_addr = b_wide[AW-1:0];

    // configuration and stream position
    always_comb begin
        thr_next      = thr_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        sz_next       = sz_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        cz_next       = cz_reg;
        slot_next     = slot_reg;
        full_next     = full_reg;
        emit_pos_next = emit_pos_reg;
        s1_valid_next = 1'b0;
        s1_next       = s1_reg;
        restart       = 1'b0;

        if (acc) begin
            s1_next.value    = s_sample;
            s1_next.side     = $signed(s_sample) >= $signed(thr_reg);
            s1_next.cx_nz    = (cx_reg != '0);
            s1_next.cy_nz    = (cy_reg != '0);
            s1_next.cz_nz    = (cz_reg != '0);
            s1_next.lastrow  = wrap_y;
            s1_next.eor      = wrap_x;
            s1_next.last     = wrap_x && wrap_y;
            s1_next.idx      = emit_pos_reg;
            s1_next.a_addr   = slot_reg;
            s1_next.b_addr   = rd_b_addr;
            s1_next.is_drain = s_mode;
            s1_next.emit     = s_mode || (cz_reg != '0);
            if ((!s_mode && !full_reg) || (s_mode && full_reg)) begin
                s1_valid_next = 1'b1;
                if (s1_next.emit) begin
                    emit_pos_next = emit_pos_reg + INDEX_W'(1);
                end
                if (wrap_x) begin
                    cx_next = '0;
                    if (wrap_y) begin
                        cy_next   = '0;
                        slot_next = '0;
                        if (!s_mode) begin
                            cz_next   = wrap_z ? '0 : cz_reg + SIZE_W'(1);
                            full_next = wrap_z;
                        end
                    end else begin
                        cy_next   = cy_reg + SIZE_W'(1);
                        slot_next = slot_reg + AW'(1);
                    end
                end else begin
                    cx_next   = cx_reg + SIZE_W'(1);
                    slot_next = slot_reg + AW'(1);
                end
                // final voxel of the volume sends everything back to the start
                if (s_mode && wrap_x && wrap_y) begin
                    emit_pos_next = '0;
                    full_next     = 1'b0;
                end
            end
        end

        if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_wr_index))
                REG_THRESHOLD: begin
                    thr_next = cfg_wr_data;
                end
                REG_SIZE_X: begin
                    sx_next = clamp_size(cfg_wr_data[SIZE_W-1:0], CLAMP_X);
                    restart = 1'b1;
                end
                REG_SIZE_Y: begin
                    sy_next = clamp_size(cfg_wr_data[SIZE_W-1:0], CLAMP_Y);
                    restart = 1'b1;
                end
                REG_SIZE_Z: begin
                    sz_next = clamp_size(cfg_wr_data[SIZE_W-1:0], CLAMP_Z);
                    restart = 1'b1;
                end
                default: begin
                    thr_next = thr_reg;
                end
            endcase
        end

        if (restart) begin
            cx_next       = '0;
            cy_next       = '0;
            cz_next       = '0;
            slot_next     = '0;
            full_next     = 1'b0;
            emit_pos_next = '0;
        end
    end

    // stage 1: resolve read data against the pending entry and last edge's write
    always_comb begin
        if (pend_valid_reg && pend_reg.slot == s1_reg.a_addr) begin
            ent_a = '{pmark: pend_reg.pmark, side: pend_reg.side, value: pend_reg.value};
        end else if (bp_valid_reg && bp_addr_reg == s1_reg.a_addr) begin
            ent_a = bp_data_reg;
        end else begin
            ent_a = rd_a_reg;
        end

        if (pend_valid_reg && pend_reg.slot == s1_reg.b_addr) begin
            ent_b = '{pmark: pend_reg.pmark, side: pend_reg.side, value: pend_reg.value};
        end else if (bp_valid_reg && bp_addr_reg == s1_reg.b_addr) begin
            ent_b = bp_data_reg;
        end else begin
            ent_b = rd_b_reg;
        end

        if (ym_bp_valid_reg && ym_bp_addr_reg == s1_reg.a_addr) begin
            ym_val = ym_bp_data_reg;
        end else begin
            ym_val = ym_rd_reg;
        end
    end

    always_comb begin
        xdiff     = s1_sample && s1_reg.cx_nz && (pend_reg.side != s1_reg.side);
        ydiff     = s1_reg.cy_nz && (ent_b.side != s1_reg.side);
        zdiff     = s1_reg.cz_nz && (ent_a.side != s1_reg.side);
        pmark_new = xdiff || ydiff || zdiff;

        // last row of a plane has no +y neighbor, so its partial mark is already final
        res.idx      = s1_reg.idx;
        res.value    = ent_a.value;
        res.crossing = (s1_reg.lastrow ? ent_a.pmark : ym_val) || (!s1_reg.is_drain && zdiff);
        res.last     = s1_reg.is_drain && s1_reg.last;

        main_we    = pend_valid_reg && (s1_sample || pend_reg.eor);
        main_wdata = '{pmark: pend_reg.pmark || xdiff, side: pend_reg.side,
                       value: pend_reg.value};

        ym_we    = s1_sample && s1_reg.cy_nz;
        ym_wdata = ent_b.pmark || (ent_b.side != s1_reg.side);

        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (s1_sample) begin
            pend_valid_next = 1'b1;
            pend_next = '{slot: s1_reg.a_addr, eor: s1_reg.eor, pmark: pmark_new,
                          side: s1_reg.side, value: s1_reg.value};
        end else if (main_we) begin
            pend_valid_next = 1'b0;
        end
        if (restart) begin
            pend_valid_next = 1'b0;
        end
    end

    // output queue, two deep
    always_comb begin
        occ_next  = occ_reg;
        out0_next = out0_reg;
        out1_next = out1_reg;
        if (pop) begin
            out0_next = out1_reg;
        end
        priority case ({push, pop})
            2'b10: begin
                occ_next = occ_reg + 2'd1;
                if (occ_reg == 2'd0) begin
                    out0_next = res;
                end else begin
                    out1_next = res;
                end
            end
            2'b11: begin
                if (occ_reg == 2'd1) begin
                    out0_next = res;
                end else begin
                    out1_next = res;
                end
            end
            2'b01: begin
                occ_next = occ_reg - 2'd1;
            end
            default: begin
                occ_next = occ_reg;
            end
        endcase
    end

    assign m_valid       = (occ_reg != 2'd0);
    assign m_voxel_index = out0_reg.idx;
    assign m_voxel_value = out0_reg.value;
    assign m_crossing    = out0_reg.crossing;
    assign m_last        = out0_reg.last;

    always_ff @(posedge aclk) begin
        if (main_we) begin
            plane_mem[pend_reg.slot] <= main_wdata;
        end
        rd_a_reg <= plane_mem[slot_reg];
        rd_b_reg <= plane_mem[rd_b_addr];
    end

    always_ff @(posedge aclk) begin
        if (ym_we) begin
            ymark_mem[s1_reg.b_addr] <= ym_wdata;
        end
        ym_rd_reg <= ymark_mem[slot_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg         <= '0;
            sx_reg          <= clamp_size(SIZE_RESET, CLAMP_X);
            sy_reg          <= clamp_size(SIZE_RESET, CLAMP_Y);
            sz_reg          <= clamp_size(SIZE_RESET, CLAMP_Z);
            cx_reg          <= '0;
            cy_reg          <= '0;
            cz_reg          <= '0;
            slot_reg        <= '0;
            full_reg        <= 1'b0;
            emit_pos_reg    <= '0;
            s1_valid_reg    <= 1'b0;
            pend_valid_reg  <= 1'b0;
            bp_valid_reg    <= 1'b0;
            ym_bp_valid_reg <= 1'b0;
            occ_reg         <= 2'd0;
        end else begin
            thr_reg         <= thr_next;
            sx_reg          <= sx_next;
            sy_reg          <= sy_next;
            sz_reg          <= sz_next;
            cx_reg          <= cx_next;
            cy_reg          <= cy_next;
            cz_reg          <= cz_next;
            slot_reg        <= slot_next;
            full_reg        <= full_next;
            emit_pos_reg    <= emit_pos_next;
            s1_valid_reg    <= s1_valid_next;
            pend_valid_reg  <= pend_valid_next;
            bp_valid_reg    <= main_we;
            ym_bp_valid_reg <= ym_we;
            occ_reg         <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_reg         <= s1_next;
        pend_reg       <= pend_next;
        bp_addr_reg    <= pend_reg.slot;
        bp_data_reg    <= main_wdata;
        ym_bp_addr_reg <= s1_reg.b_addr;
        ym_bp_data_reg <= ym_wdata;
        out0_reg       <= out0_next;
        out1_reg       <= out1_next;
    end

endmodule

`default_nettype wire

// File: rtl/icvf_checker.sv
// port-level checks of the isosurface crossing voxel finder and their bind
`default_nettype none

module icvf_checker
    import icvf_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [INDEX_W-1:0] m_voxel_index,
    input wire logic [VALUE_W-1:0] m_voxel_value,
    input wire logic               m_crossing,
    input wire logic               m_last
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_voxel_index) && $stable(m_voxel_value)
            && $stable(m_crossing) && $stable(m_last))
    else $error("result changed while stalled");

    // a newly raised result must come from an accepted input transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
    else $error("result without an input transaction two cycles before");

    // input side only backs off when a result is waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
    else $error("input stalled with no result pending");

    // a taken result always frees room for a new transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |-> s_ready)
    else $error("input stalled while a result is taken");

endmodule

bind isosurface_crossing_voxel_finder icvf_checker u_icvf_checker (.*);

`default_nettype wire
